@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lrd_pkg.sv @@
package lrd_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD_BYTES = 8'd1;

  localparam logic [7:0]  EXPECTED_VERSION_RST  = 8'd1;
  localparam logic [31:0] MAX_PAYLOAD_BYTES_RST = 32'd4096;

  localparam logic [4:0]  HDR_LAST  = 5'd23;
  localparam logic [15:0] HDR_BYTES = 16'd24;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  localparam logic [2:0] OUTCOME_OK          = 3'd0;
  localparam logic [2:0] OUTCOME_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] OUTCOME_BAD_VERSION = 3'd2;
  localparam logic [2:0] OUTCOME_BAD_SIZE    = 3'd3;
  localparam logic [2:0] OUTCOME_TOO_LONG    = 3'd4;
  localparam logic [2:0] OUTCOME_CRC_BAD     = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_record;
  } in_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        record_end;
    logic [2:0]  outcome;
    logic [7:0]  record_type;
    logic [31:0] record_length;
    logic [63:0] record_time_ms;
    logic [31:0] stored_crc;
    logic [31:0] computed_crc;
  } out_item_t;

  // "ALOG"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h41;
      2'd1:    m = 8'h4c;
      2'd2:    m = 8'h4f;
      default: m = 8'h47;
    endcase
    return m;
  endfunction

  // Reflected CRC-32, one byte, bit-at-a-time unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ src/lrd_core.sv @@
module lrd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [lrd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lrd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                          accept,
  input  lrd_pkg::in_item_t             item,
  output lrd_pkg::out_item_t            result
);

  logic [7:0]  expected_version;
  logic [31:0] max_payload_bytes;

  logic        in_payload, in_payload_next;
  logic [4:0]  header_position, header_position_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [31:0] crc_running, crc_running_next;
  logic        magic_match, magic_match_next;
  logic [7:0]  hdr_version, hdr_version_next;
  logic [15:0] hdr_size, hdr_size_next;
  logic [7:0]  hdr_type, hdr_type_next;
  logic [31:0] hdr_length, hdr_length_next;
  logic [63:0] hdr_time, hdr_time_next;
  logic [31:0] hdr_crc, hdr_crc_next;

  logic [7:0]  b;
  logic [4:0]  pos;
  logic [4:0]  time_off;
  logic [31:0] crc_upd;
  logic [31:0] crc_fin;
  logic [2:0]  code;
  logic        restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version  <= lrd_pkg::EXPECTED_VERSION_RST;
      max_payload_bytes <= lrd_pkg::MAX_PAYLOAD_BYTES_RST;
    end else if (cfg_valid) begin
      if (cfg_index == lrd_pkg::REG_EXPECTED_VERSION) begin
        expected_version <= cfg_data[7:0];
      end else if (cfg_index == lrd_pkg::REG_MAX_PAYLOAD_BYTES) begin
        max_payload_bytes <= cfg_data[31:0];
      end
    end
  end

  always_comb begin
    b   = item.data_byte;
    // start flag drops any partial record
    in_payload_next        = item.start_of_record ? 1'b0 : in_payload;
    pos                    = item.start_of_record ? 5'd0 : header_position;
    payload_remaining_next = item.start_of_record ? 32'd0 : payload_remaining;
    crc_running_next       = item.start_of_record ? lrd_pkg::CRC_INIT : crc_running;
    magic_match_next       = item.start_of_record ? 1'b1 : magic_match;
    header_position_next   = pos;
    hdr_version_next = hdr_version;
    hdr_size_next    = hdr_size;
    hdr_type_next    = hdr_type;
    hdr_length_next  = hdr_length;
    hdr_time_next    = hdr_time;
    hdr_crc_next     = hdr_crc;
    time_off = pos - 5'd12;
    crc_upd  = lrd_pkg::crc_byte(crc_running_next, b);
    crc_fin  = 32'd0;
    code     = lrd_pkg::OUTCOME_OK;
    restart  = 1'b0;

    result = '0;

    if (in_payload_next) begin
      result.payload_valid   = 1'b1;
      result.payload_byte    = b;
      crc_running_next       = crc_upd;
      payload_remaining_next = payload_remaining_next - 32'd1;
      if (payload_remaining_next == 32'd0) begin
        crc_fin = crc_upd ^ lrd_pkg::CRC_INIT;
        result.record_end   = 1'b1;
        result.computed_crc = crc_fin;
        result.outcome = (crc_fin == hdr_crc) ? lrd_pkg::OUTCOME_OK
                                              : lrd_pkg::OUTCOME_CRC_BAD;
        restart = 1'b1;
      end
    end else begin
      case (pos) inside
        [5'd0:5'd3]: begin
          if (b != lrd_pkg::magic_byte(pos[1:0])) begin
            magic_match_next = 1'b0;
          end
        end
        5'd4:          hdr_version_next = b;
        5'd5:          hdr_type_next = b;
        [5'd6:5'd7]:   hdr_size_next[{pos[0], 3'b000} +: 8] = b;
        [5'd8:5'd11]:  hdr_length_next[{pos[1:0], 3'b000} +: 8] = b;
        [5'd12:5'd19]: hdr_time_next[{time_off[2:0], 3'b000} +: 8] = b;
        default:       hdr_crc_next[{pos[1:0], 3'b000} +: 8] = b;
      endcase
      if (pos >= 5'd4 && pos < 5'd20) begin
        crc_running_next = crc_upd;
      end

      if (pos != lrd_pkg::HDR_LAST) begin
        header_position_next = pos + 5'd1;
      end else begin
        if (!magic_match_next) begin
          code = lrd_pkg::OUTCOME_BAD_MAGIC;
        end else if (hdr_version != expected_version) begin
          code = lrd_pkg::OUTCOME_BAD_VERSION;
        end else if (hdr_size != lrd_pkg::HDR_BYTES) begin
          code = lrd_pkg::OUTCOME_BAD_SIZE;
        end else if (hdr_length > max_payload_bytes) begin
          code = lrd_pkg::OUTCOME_TOO_LONG;
        end
        if (code != lrd_pkg::OUTCOME_OK) begin
          result.record_end = 1'b1;
          result.outcome    = code;
          restart = 1'b1;
        end else if (hdr_length == 32'd0) begin
          // empty payload: compare right at the last header byte
          crc_fin = crc_running_next ^ lrd_pkg::CRC_INIT;
          result.record_end   = 1'b1;
          result.computed_crc = crc_fin;
          result.outcome = (crc_fin == hdr_crc_next) ? lrd_pkg::OUTCOME_OK
                                                     : lrd_pkg::OUTCOME_CRC_BAD;
          restart = 1'b1;
        end else begin
          in_payload_next        = 1'b1;
          header_position_next   = 5'd0;
          payload_remaining_next = hdr_length;
        end
      end
    end

    if (restart) begin
      in_payload_next        = 1'b0;
      header_position_next   = 5'd0;
      payload_remaining_next = 32'd0;
      crc_running_next       = lrd_pkg::CRC_INIT;
      magic_match_next       = 1'b1;
    end

    result.record_type    = hdr_type_next;
    result.record_length  = hdr_length_next;
    result.record_time_ms = hdr_time_next;
    result.stored_crc     = hdr_crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload        <= 1'b0;
      header_position   <= 5'd0;
      payload_remaining <= 32'd0;
      crc_running       <= lrd_pkg::CRC_INIT;
      magic_match       <= 1'b1;
      hdr_version       <= 8'd0;
      hdr_size          <= 16'd0;
      hdr_type          <= 8'd0;
      hdr_length        <= 32'd0;
      hdr_time          <= 64'd0;
      hdr_crc           <= 32'd0;
    end else if (accept) begin
      in_payload        <= in_payload_next;
      header_position   <= header_position_next;
      payload_remaining <= payload_remaining_next;
      crc_running       <= crc_running_next;
      magic_match       <= magic_match_next;
      hdr_version       <= hdr_version_next;
      hdr_size          <= hdr_size_next;
      hdr_type          <= hdr_type_next;
      hdr_length        <= hdr_length_next;
      hdr_time          <= hdr_time_next;
      hdr_crc           <= hdr_crc_next;
    end
  end

endmodule

@@ src/lrd_out_reg.sv @@
module lrd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  lrd_pkg::out_item_t load_data,
  output logic               can_load,
  output logic               result_valid,
  input  logic               result_ready,
  output lrd_pkg::out_item_t result
);

  // refill in the same cycle the held item drains
  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

@@ src/log_record_deframer_crc32_unit.sv @@
// A result is registered and shown in the cycle after its byte is accepted.
// Throughput: one byte per cycle while result_ready keeps the output free; the
// byte-wide CRC update, the header position counter and the header checks sit
// between the state registers and the output register.
// Reset (rst, synchronous): parser expects header byte 0, CRC all ones,
// header fields zero, expected_version 1, max_payload_bytes 4096, no result held.
module log_record_deframer_crc32_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  lrd_pkg::in_item_t               byte_item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output lrd_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic               accept;
  lrd_pkg::out_item_t core_result;

  assign cfg_ready = 1'b1;
  assign accept    = byte_valid && byte_ready;

  lrd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (byte_item),
    .result    (core_result)
  );

  lrd_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .load_data    (core_result),
    .can_load     (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ src/lrd_checker.sv @@
`include "assert_macros.svh"

module lrd_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input lrd_pkg::out_item_t result
);

  logic stalled;
  logic shown_mid;
  logic shown_hdr_fail;
  logic shown_no_payload;
  logic mid_fields_zero;
  logic crc_zero;
  logic byte_zero;

  assign stalled          = result_valid && !result_ready;
  assign shown_mid        = result_valid && !result.record_end;
  // header failures never compare CRCs
  assign shown_hdr_fail   = result_valid && result.record_end &&
                            result.outcome != lrd_pkg::OUTCOME_OK &&
                            result.outcome != lrd_pkg::OUTCOME_CRC_BAD;
  assign shown_no_payload = result_valid && !result.payload_valid;
  assign crc_zero         = result.computed_crc == 32'd0;
  assign mid_fields_zero  = result.outcome == lrd_pkg::OUTCOME_OK && crc_zero;
  assign byte_zero        = result.payload_byte == 8'd0;

  `ASSERT_CLK(a_hold, clk, rst, stalled |=> result_valid && $stable(result), "result not held")

  `ASSERT_CLK(a_mid_clean, clk, rst, shown_mid |-> mid_fields_zero, "outcome or crc mid record")

  `ASSERT_CLK(a_fail_crc, clk, rst, shown_hdr_fail |-> crc_zero, "crc on header failure")

  `ASSERT_CLK(a_payload_zero, clk, rst, shown_no_payload |-> byte_zero, "payload byte not zero")

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")

endmodule

bind log_record_deframer_crc32_unit lrd_checker u_lrd_checker (.*);

@@ tb/tb_log_record_deframer_crc32_unit.sv @@
module tb_log_record_deframer_crc32_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lrd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam bit [31:0] MAGIC_WORD = "ALOG";

  class record_scoreboard;
    bit [7:0]  want_version;
    bit [31:0] len_limit;
    bit        in_body;
    bit [4:0]  hdr_pos;
    bit [31:0] body_left;
    bit [31:0] crc_acc;
    bit        magic_ok;
    bit [7:0]  f_version;
    bit [15:0] f_size;
    bit [7:0]  f_type;
    bit [31:0] f_length;
    bit [63:0] f_time;
    bit [31:0] f_crc;
    out_item_t due_results[$];
    int        errors;

    function new();
      want_version = EXPECTED_VERSION_RST;
      len_limit    = MAX_PAYLOAD_BYTES_RST;
      restart();
      f_version = '0;
      f_size    = '0;
      f_type    = '0;
      f_length  = '0;
      f_time    = '0;
      f_crc     = '0;
      errors    = 0;
    endfunction

    static function bit [31:0] crc32_step(bit [31:0] c, bit [7:0] d);
      bit [31:0] r;
      r = c ^ {24'h0, d};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void restart();
      in_body   = 1'b0;
      hdr_pos   = '0;
      body_left = '0;
      crc_acc   = CRC_INIT;
      magic_ok  = 1'b1;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_EXPECTED_VERSION) want_version = val[7:0];
      else if (idx == REG_MAX_PAYLOAD_BYTES) len_limit = val;
    endfunction

    // CRC compare at the end of a record, then back to header byte 0
    function void close_record(inout out_item_t r);
      bit [31:0] fin;
      fin = crc_acc ^ CRC_INIT;
      r.record_end   = 1'b1;
      r.computed_crc = fin;
      r.outcome      = (fin == f_crc) ? OUTCOME_OK : OUTCOME_CRC_BAD;
      restart();
    endfunction

    function void note_byte(in_item_t it);
      out_item_t r;
      bit [7:0]  b;
      bit [2:0]  code;
      int        p;
      r = '0;
      b = it.data_byte;
      if (it.start_of_record) restart();
      if (in_body) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        crc_acc   = crc32_step(crc_acc, b);
        body_left = body_left - 32'd1;
        if (body_left == 0) close_record(r);
      end else begin
        p = hdr_pos;
        if (p < 4) begin
          if (b != MAGIC_WORD[8*(3-p) +: 8]) magic_ok = 1'b0;
        end else if (p == 4) begin
          f_version = b;
        end else if (p == 5) begin
          f_type = b;
        end else if (p < 8) begin
          f_size[8*(p-6) +: 8] = b;
        end else if (p < 12) begin
          f_length[8*(p-8) +: 8] = b;
        end else if (p < 20) begin
          f_time[8*(p-12) +: 8] = b;
        end else begin
          f_crc[8*(p-20) +: 8] = b;
        end
        if (p >= 4 && p < 20) crc_acc = crc32_step(crc_acc, b);
        if (hdr_pos != HDR_LAST) begin
          hdr_pos = hdr_pos + 5'd1;
        end else begin
          // first failing check wins
          if (!magic_ok) code = OUTCOME_BAD_MAGIC;
          else if (f_version != want_version) code = OUTCOME_BAD_VERSION;
          else if (f_size != HDR_BYTES) code = OUTCOME_BAD_SIZE;
          else if (f_length > len_limit) code = OUTCOME_TOO_LONG;
          else code = OUTCOME_OK;
          if (code != OUTCOME_OK) begin
            r.record_end = 1'b1;
            r.outcome    = code;
            restart();
          end else if (f_length == 0) begin
            close_record(r);
          end else begin
            in_body   = 1'b1;
            hdr_pos   = '0;
            body_left = f_length;
          end
        end
      end
      r.record_type    = f_type;
      r.record_length  = f_length;
      r.record_time_ms = f_time;
      r.stored_crc     = f_crc;
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("payload_valid", want.payload_valid, got.payload_valid);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("record_end", want.record_end, got.record_end);
      check_field("outcome", want.outcome, got.outcome);
      check_field("record_type", want.record_type, got.record_type);
      check_field("record_length", want.record_length, got.record_length);
      check_field("record_time_ms", want.record_time_ms, got.record_time_ms);
      check_field("stored_crc", want.stored_crc, got.stored_crc);
      check_field("computed_crc", want.computed_crc, got.computed_crc);
    endfunction

    function int waiting();
      return due_results.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  in_item_t               byte_item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  out_item_t              result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  record_scoreboard records = new();
  in_item_t         stream_q[$];
  int               sent = 0;
  int               cycles = 0;
  bit               steady = 1'b0;

  log_record_deframer_crc32_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) records.check_result(result);
      result_ready <= !(!steady && $urandom_range(99) < 6);
    end
  end

  task automatic send_byte(input in_item_t it);
    if (!steady && $urandom_range(99) < 6) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (!byte_ready);
    records.note_byte(it);
    sent++;
  endtask

  task automatic play_stream();
    in_item_t it;
    while (stream_q.size() != 0) begin
      it = stream_q.pop_front();
      send_byte(it);
    end
  endtask

  // sender holds off until every pending result is back
  task automatic drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (records.waiting() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    records.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic sor);
    in_item_t it;
    it.data_byte       = b;
    it.start_of_record = sor;
    stream_q.push_back(it);
  endfunction

  // One record: header with a CRC over bytes 4..19 and the payload, and body_n payload bytes.
  // fill < 0 gives random payload bytes.
  function automatic void add_record(input bit sor, input bit [7:0] ver, input bit [7:0] kind,
                                     input bit [15:0] hsize, input bit [31:0] len,
                                     input int body_n, input bit bad_magic, input bit bad_crc,
                                     input int fill, input bit [63:0] stamp);
    bit [7:0]  hdr[24];
    bit [7:0]  body[$];
    bit [31:0] c;
    for (int i = 0; i < 4; i++) hdr[i] = MAGIC_WORD[8*(3-i) +: 8];
    if (bad_magic) hdr[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
    hdr[4] = ver;
    hdr[5] = kind;
    hdr[6] = hsize[7:0];
    hdr[7] = hsize[15:8];
    for (int i = 0; i < 4; i++) hdr[8+i] = len[8*i +: 8];
    for (int i = 0; i < 8; i++) hdr[12+i] = stamp[8*i +: 8];
    c = CRC_INIT;
    for (int i = 4; i < 20; i++) c = record_scoreboard::crc32_step(c, hdr[i]);
    for (int i = 0; i < body_n; i++) begin
      body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      c = record_scoreboard::crc32_step(c, body[i]);
    end
    c = c ^ CRC_INIT;
    if (bad_crc) c ^= 32'd1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) hdr[20+i] = c[8*i +: 8];
    for (int i = 0; i < 24; i++) add_byte(hdr[i], (i == 0) ? sor : 1'b0);
    foreach (body[i]) add_byte(body[i], 1'b0);
  endfunction

  task automatic random_traffic(input int n_bytes);
    int        stop_at;
    int        roll;
    int        body_n;
    bit [31:0] len_cap;
    bit [31:0] len;
    bit [7:0]  ver;
    bit [15:0] hsize;
    bit        resync;
    bit        bad_magic;
    bit        bad_crc;
    stop_at = sent + n_bytes;
    resync  = 1'b1;
    while (sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        // line noise, parsed as header garbage
        repeat ($urandom_range(8, 1)) add_byte(8'($urandom), $urandom_range(9) == 0);
        resync = 1'b1;
      end else begin
        ver       = records.want_version;
        hsize     = HDR_BYTES;
        bad_magic = 1'b0;
        bad_crc   = ($urandom_range(99) < 8);
        len_cap   = (records.len_limit < 48) ? records.len_limit : 32'd48;
        len       = $urandom_range(len_cap, 0);
        body_n    = len;
        if (roll < 14) begin
          body_n = 0;
          case ($urandom_range(3))
            0: bad_magic = 1'b1;
            1: ver = ver ^ 8'($urandom_range(255, 1));
            2: begin
              hsize = 16'($urandom);
              if (hsize == HDR_BYTES) hsize = ~hsize;
            end
            default: begin
              if (records.len_limit != '1) len = records.len_limit + 32'd1;
              else bad_magic = 1'b1;
            end
          endcase
        end else if (roll < 20) begin
          // cut short, next record must force a resync
          if (records.len_limit > 1000 && $urandom_range(1))
            len = $urandom_range(records.len_limit, 49);
          body_n = (len > 12) ? $urandom_range(12) : $urandom_range(len);
        end
        add_record(resync || $urandom_range(3) == 0, ver, 8'($urandom), hsize, len, body_n,
                   bad_magic, bad_crc, -1, {$urandom, $urandom});
        resync = (body_n < len) && (roll >= 14);
      end
      play_stream();
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: version 1, limit 4096
    add_record(1, 8'd1, 8'h00, HDR_BYTES, 0, 0, 0, 0, -1, '0);
    add_record(0, 8'd1, 8'hff, HDR_BYTES, 0, 0, 0, 1, -1, '1);
    add_record(0, 8'd1, 8'($urandom), HDR_BYTES, 3, 3, 0, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd1, 8'h5a, HDR_BYTES, 4, 4, 0, 0, 8'h00, '1);
    add_record(0, 8'd1, 8'ha5, HDR_BYTES, 4, 4, 0, 0, 8'hff, '0);
    add_record(0, 8'd1, 8'h11, HDR_BYTES, 5, 5, 0, 1, -1, {$urandom, $urandom});
    add_record(0, 8'd1, 8'h22, HDR_BYTES, 2, 0, 1, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd2, 8'h33, HDR_BYTES, 2, 0, 1, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd0, 8'h44, 16'hffff, 2, 0, 0, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd1, 8'h55, 16'hffff, 5000, 0, 0, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd1, 8'h66, 16'd0, 1, 0, 0, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd1, 8'h77, HDR_BYTES, 4097, 0, 0, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd1, 8'h88, HDR_BYTES, 4096, 3, 0, 0, -1, {$urandom, $urandom});
    add_record(1, 8'd1, 8'h99, HDR_BYTES, 10, 4, 0, 0, -1, {$urandom, $urandom});
    // resync in the middle of a header
    add_byte(8'h41, 1'b1);
    repeat (9) add_byte(8'($urandom), 1'b0);
    add_record(1, 8'd1, 8'hee, HDR_BYTES, 2, 2, 0, 0, -1, {$urandom, $urandom});
    play_stream();

    // smallest settings: version 0, no payload allowed
    drain();
    write_reg(REG_EXPECTED_VERSION, 32'd0);
    write_reg(REG_MAX_PAYLOAD_BYTES, 32'd0);
    add_record(1, 8'd0, 8'h01, HDR_BYTES, 0, 0, 0, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd0, 8'h02, HDR_BYTES, 1, 0, 0, 0, -1, {$urandom, $urandom});
    add_record(0, 8'd1, 8'h03, HDR_BYTES, 0, 0, 0, 0, -1, {$urandom, $urandom});
    play_stream();
    random_traffic(200);

    // largest settings, no idling on either side
    drain();
    steady = 1'b1;
    write_reg(REG_EXPECTED_VERSION, 32'd255);
    write_reg(REG_MAX_PAYLOAD_BYTES, 32'hffff_ffff);
    add_record(1, 8'd255, 8'h04, HDR_BYTES, 32'hffff_ffff, 6, 0, 0, -1, '1);
    add_record(1, 8'd255, 8'h05, HDR_BYTES, 3, 3, 0, 0, -1, {$urandom, $urandom});
    play_stream();
    random_traffic(300);

    drain();
    steady = 1'b0;
    write_reg(REG_EXPECTED_VERSION, 32'($urandom_range(255)));
    write_reg(REG_MAX_PAYLOAD_BYTES, 32'($urandom_range(64, 8)));
    random_traffic(300);

    drain();
    write_reg(REG_EXPECTED_VERSION, 32'(EXPECTED_VERSION_RST));
    write_reg(REG_MAX_PAYLOAD_BYTES, MAX_PAYLOAD_BYTES_RST);
    random_traffic(300);

    drain();
    repeat (4) @(posedge clk);
    if (records.errors == 0 && records.waiting() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
